// ----- src/vsa_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// voice slot allocator. No dependencies.
package vsa_pkg;

  localparam int unsigned VOICES   = 16;
  localparam int unsigned IDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned SOUND_W  = 16;
  localparam int unsigned REQ_W    = 16;
  localparam int unsigned STAMP_W  = 64;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VOL_W    = 7;
  localparam int unsigned PITCH_W  = 8;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_STARTED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LOAD_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STOPPED   = 2'd2;

  // Request function codes.
  localparam logic FN_PLAY = 1'b0;
  localparam logic FN_STOP = 1'b1;

  // Clamp limits.
  localparam logic signed [REQ_W-1:0] VOL_MIN   = 16'sd0;
  localparam logic signed [REQ_W-1:0] VOL_MAX   = 16'sd100;
  localparam logic signed [REQ_W-1:0] PITCH_MIN = 16'sd50;
  localparam logic signed [REQ_W-1:0] PITCH_MAX = 16'sd200;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             latch;
    logic             clear_all;
    logic             scan_en;
    logic             commit;
    logic [IDX_W-1:0] scan_idx;
  } vsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_stop;
    logic any_free;
  } vsa_stat_t;

endpackage

// ----- src/voice_slot_allocator_core.sv -----
// Top level of the voice slot allocator: a controller and a datapath.
// Depends on vsa_pkg, vsa_ctrl and vsa_dp.
//
// Usage. A request word (func_i, sound_id_i, volume_req_i, pitch_req_i,
// playing_mask_i, load_ok_i) is taken at a rising edge where start is high
// and busy is low. One result word comes back for every request, shown on
// slot_o, status_o, load_needed_o, evicted_o, volume_pct_o and pitch_pct_o
// for exactly one cycle while valid_o is high.
// Timing. A stop request passes through the check state, which clears every
// slot, and busy drops as its result appears. A play request that finds an
// unused slot passes through the check and commit states. When every slot is
// in use, the datapath walks the stamp table one entry per cycle with a single
// 64-bit comparator pair between the check and commit states. The result
// appears in the first cycle in which busy is low, and a new request may be
// accepted in that same cycle.
// Reset clears every slot and the play counter; no clearing pass is needed.
// The receiver cannot stall: each result word must be taken in its cycle.
module voice_slot_allocator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic [vsa_pkg::SOUND_W-1:0]         sound_id_i,
  input  logic signed [vsa_pkg::REQ_W-1:0]    volume_req_i,
  input  logic signed [vsa_pkg::REQ_W-1:0]    pitch_req_i,
  input  logic [vsa_pkg::MASK_W-1:0]          playing_mask_i,
  input  logic                                load_ok_i,
  output logic                                valid_o,
  output logic [vsa_pkg::SLOT_W-1:0]          slot_o,
  output logic [vsa_pkg::STATUS_W-1:0]        status_o,
  output logic                                load_needed_o,
  output logic                                evicted_o,
  output logic [vsa_pkg::VOL_W-1:0]           volume_pct_o,
  output logic [vsa_pkg::PITCH_W-1:0]         pitch_pct_o
);

  // Commands flow from the controller to the datapath; the datapath reports
  // whether the request is a stop and whether any slot is still unused.
  vsa_pkg::vsa_cmd_t  cmd;
  vsa_pkg::vsa_stat_t stat;

  vsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // The datapath holds the slot tables, runs the oldest-stamp scan and
  // registers the result word.
  vsa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (func_i),
    .sound_id_i     (sound_id_i),
    .volume_req_i   (volume_req_i),
    .pitch_req_i    (pitch_req_i),
    .playing_mask_i (playing_mask_i),
    .load_ok_i      (load_ok_i),
    .valid_o        (valid_o),
    .slot_o         (slot_o),
    .status_o       (status_o),
    .load_needed_o  (load_needed_o),
    .evicted_o      (evicted_o),
    .volume_pct_o   (volume_pct_o),
    .pitch_pct_o    (pitch_pct_o)
  );

endmodule

// ----- src/vsa_ctrl.sv -----
// Sequencing state machine of the voice slot allocator.
// Depends on vsa_pkg for the command and status types.
module vsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  vsa_pkg::vsa_stat_t  stat_i,
  output vsa_pkg::vsa_cmd_t   cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  localparam logic [vsa_pkg::IDX_W-1:0] LAST_IDX = vsa_pkg::IDX_W'(vsa_pkg::VOICES - 1);

  logic [1:0]                state_q, state_d;
  logic [vsa_pkg::IDX_W-1:0] idx_q, idx_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d           = state_q;
    idx_d             = idx_q;
    cmd_o             = '0;
    cmd_o.scan_idx    = idx_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.is_stop) begin
          cmd_o.clear_all = 1'b1;
          state_d         = S_IDLE;
        end else if (stat_i.any_free) begin
          state_d = S_COMMIT;
        end else begin
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = S_COMMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ----- src/vsa_dp.sv -----
// Datapath of the voice slot allocator: slot tables, stamp scan, update
// and result registers. Depends on vsa_pkg.
module vsa_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  vsa_pkg::vsa_cmd_t                      cmd_i,
  output vsa_pkg::vsa_stat_t                     stat_o,
  input  logic                                   func_i,
  input  logic [vsa_pkg::SOUND_W-1:0]            sound_id_i,
  input  logic signed [vsa_pkg::REQ_W-1:0]       volume_req_i,
  input  logic signed [vsa_pkg::REQ_W-1:0]       pitch_req_i,
  input  logic [vsa_pkg::MASK_W-1:0]             playing_mask_i,
  input  logic                                   load_ok_i,
  output logic                                   valid_o,
  output logic [vsa_pkg::SLOT_W-1:0]             slot_o,
  output logic [vsa_pkg::STATUS_W-1:0]           status_o,
  output logic                                   load_needed_o,
  output logic                                   evicted_o,
  output logic [vsa_pkg::VOL_W-1:0]              volume_pct_o,
  output logic [vsa_pkg::PITCH_W-1:0]            pitch_pct_o
);

  localparam int unsigned N  = vsa_pkg::VOICES;
  localparam int unsigned IW = vsa_pkg::IDX_W;

  // Latched request word.
  logic                              func_q;
  logic [vsa_pkg::SOUND_W-1:0]       sid_q;
  logic signed [vsa_pkg::REQ_W-1:0]  vol_q;
  logic signed [vsa_pkg::REQ_W-1:0]  pit_q;
  logic [vsa_pkg::MASK_W-1:0]        mask_q;
  logic                              load_ok_q;

  // Slot tables.
  logic [N-1:0]                      in_use_q;
  logic [vsa_pkg::SOUND_W-1:0]       sound_q [N];
  logic [vsa_pkg::STAMP_W-1:0]       stamp_q [N];
  logic [vsa_pkg::STAMP_W-1:0]       counter_q;

  // Scan bests.
  logic                              idle_found_q, any_found_q;
  logic [IW-1:0]                     best_idle_q, best_any_q;
  logic [vsa_pkg::STAMP_W-1:0]       best_idle_stamp_q, best_any_stamp_q;

  // Result registers.
  logic                              valid_q;
  logic [IW-1:0]                     pick_q;
  logic [vsa_pkg::STATUS_W-1:0]      status_q;
  logic                              load_q, evict_q;
  logic [vsa_pkg::VOL_W-1:0]         vol_out_q;
  logic [vsa_pkg::PITCH_W-1:0]       pit_out_q;

  logic [N-1:0]                      playing;
  logic [IW-1:0]                     free_idx;
  logic                              any_free;
  logic [IW-1:0]                     pick;
  logic                              hit;
  logic [vsa_pkg::STAMP_W-1:0]       cnt_inc;
  logic [vsa_pkg::STAMP_W-1:0]       scan_stamp;
  logic                              scan_idle;
  logic [vsa_pkg::VOL_W-1:0]         vol_clamp;
  logic [vsa_pkg::PITCH_W-1:0]       pit_clamp;

  // Slots beyond the mask width always count as idle.
  for (genvar g = 0; g < N; g++) begin : g_play
    if (g < vsa_pkg::MASK_W) begin : g_bit
      assign playing[g] = mask_q[g];
    end else begin : g_none
      assign playing[g] = 1'b0;
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign any_free      = ~&in_use_q;
  assign stat_o.any_free = any_free;
  assign stat_o.is_stop  = (func_q == vsa_pkg::FN_STOP);

  assign pick    = any_free ? free_idx : (idle_found_q ? best_idle_q : best_any_q);
  assign hit     = in_use_q[pick] && (sound_q[pick] == sid_q);
  assign cnt_inc = counter_q + 1'b1;

  assign scan_stamp = stamp_q[cmd_i.scan_idx];
  assign scan_idle  = !playing[cmd_i.scan_idx];

  always_comb begin
    if (vol_q < vsa_pkg::VOL_MIN) begin
      vol_clamp = '0;
    end else if (vol_q > vsa_pkg::VOL_MAX) begin
      vol_clamp = vsa_pkg::VOL_W'(vsa_pkg::VOL_MAX);
    end else begin
      vol_clamp = vol_q[vsa_pkg::VOL_W-1:0];
    end
    if (pit_q < vsa_pkg::PITCH_MIN) begin
      pit_clamp = vsa_pkg::PITCH_W'(vsa_pkg::PITCH_MIN);
    end else if (pit_q > vsa_pkg::PITCH_MAX) begin
      pit_clamp = vsa_pkg::PITCH_W'(vsa_pkg::PITCH_MAX);
    end else begin
      pit_clamp = pit_q[vsa_pkg::PITCH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q    <= func_i;
      sid_q     <= sound_id_i;
      vol_q     <= volume_req_i;
      pit_q     <= pitch_req_i;
      mask_q    <= playing_mask_i;
      load_ok_q <= load_ok_i;
    end
  end

  // Sound and stamp entries matter only while the slot is in use.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (hit) begin
        stamp_q[pick] <= cnt_inc;
      end else if (load_ok_q) begin
        sound_q[pick] <= sid_q;
        stamp_q[pick] <= cnt_inc;
      end else begin
        sound_q[pick] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q  <= '0;
      counter_q <= '0;
    end else if (cmd_i.clear_all) begin
      in_use_q  <= '0;
      counter_q <= '0;
    end else if (cmd_i.commit) begin
      if (hit || load_ok_q) begin
        counter_q <= cnt_inc;
      end
      if (!hit) begin
        in_use_q[pick] <= load_ok_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_found_q <= 1'b0;
      any_found_q  <= 1'b0;
    end else if (cmd_i.latch) begin
      idle_found_q <= 1'b0;
      any_found_q  <= 1'b0;
    end else if (cmd_i.scan_en && in_use_q[cmd_i.scan_idx]) begin
      if (!any_found_q || (scan_stamp < best_any_stamp_q)) begin
        any_found_q <= 1'b1;
      end
      if (scan_idle && (!idle_found_q || (scan_stamp < best_idle_stamp_q))) begin
        idle_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en && in_use_q[cmd_i.scan_idx]) begin
      if (!any_found_q || (scan_stamp < best_any_stamp_q)) begin
        best_any_q       <= cmd_i.scan_idx;
        best_any_stamp_q <= scan_stamp;
      end
      if (scan_idle && (!idle_found_q || (scan_stamp < best_idle_stamp_q))) begin
        best_idle_q       <= cmd_i.scan_idx;
        best_idle_stamp_q <= scan_stamp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.clear_all | cmd_i.commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_all) begin
      pick_q    <= '0;
      status_q  <= vsa_pkg::ST_STOPPED;
      load_q    <= 1'b0;
      evict_q   <= 1'b0;
      vol_out_q <= '0;
      pit_out_q <= '0;
    end else if (cmd_i.commit) begin
      pick_q    <= pick;
      status_q  <= (hit || load_ok_q) ? vsa_pkg::ST_STARTED : vsa_pkg::ST_LOAD_FAIL;
      load_q    <= !hit;
      evict_q   <= !hit && in_use_q[pick];
      vol_out_q <= vol_clamp;
      pit_out_q <= pit_clamp;
    end
  end

  assign valid_o       = valid_q;
  assign slot_o        = vsa_pkg::SLOT_W'(pick_q);
  assign status_o      = status_q;
  assign load_needed_o = load_q;
  assign evicted_o     = evict_q;
  assign volume_pct_o  = vol_out_q;
  assign pitch_pct_o   = pit_out_q;

  // A result word lasts a single cycle; results never come back to back.
  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q) else $error("result strobe held for two cycles");

  // A stop result coincides with a fully cleared pool and counter.
  a_stop_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (status_q == vsa_pkg::ST_STOPPED)) |-> ((in_use_q == '0) && (counter_q == '0)))
    else $error("stop result with state left behind");

  // A started voice holds its slot.
  a_start_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (status_q == vsa_pkg::ST_STARTED)) |-> in_use_q[pick_q])
    else $error("started voice not marked in use");

  // A failed load leaves its slot free.
  a_fail_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (status_q == vsa_pkg::ST_LOAD_FAIL)) |-> !in_use_q[pick_q])
    else $error("failed load left slot in use");

endmodule
